// ----- sv/lsep_pkg.sv -----
`timescale 1ns / 1ps
package lsep_pkg;

   localparam int COORD_W    = 16;
   localparam int MASS_IN_W  = 20;
   localparam int AREA_W     = 16;
   localparam int RADIUS_W   = 12;
   localparam int FACTOR_W   = 8;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int MAX_SPOTS_DEF   = 128;
   localparam int MAX_ERASERS_DEF = 8;
   localparam int MAX_PENS_DEF    = 16;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd120;
   localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd1;

   localparam logic [KIND_W-1:0] KIND_ERASER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PEN    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_RADIUS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASER_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASER_ENABLE = 2'd2;

   typedef struct packed {
      logic [RADIUS_W-1:0] merge_radius;
      logic [FACTOR_W-1:0] eraser_factor;
      logic                eraser_enable;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [MASS_IN_W-1:0]      mass;
      logic [AREA_W-1:0]         area;
   } spot_type;

   function automatic int cnt_w(int n);
      return $clog2(n + 1);
   endfunction

   function automatic int idx_w(int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// ----- sv/lsep_ram.sv -----
`timescale 1ns / 1ps
module lsep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [lsep_pkg::idx_w(DEPTH)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [lsep_pkg::idx_w(DEPTH)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   import lsep_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lsep_front.sv -----
`timescale 1ns / 1ps
module lsep_front #(
   parameter int MAX_SPOTS = lsep_pkg::MAX_SPOTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lsep_pkg::spot_type                    req_spot,
   input  logic                                  req_last_spot,
   input  logic                                  req_frame_empty,
   output logic                                  wr_en,
   output logic [lsep_pkg::idx_w(MAX_SPOTS)-1:0] wr_addr,
   output lsep_pkg::spot_type                    wr_data,
   output logic                                  push,
   output logic [lsep_pkg::cnt_w(MAX_SPOTS)-1:0] push_count,
   input  logic                                  frame_done
);
   import lsep_pkg::*;

   localparam int CNT_W = cnt_w(MAX_SPOTS);
   localparam int IDX_W = idx_w(MAX_SPOTS);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             accept, store, frame_end;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign store     = accept && !req_frame_empty && (cnt_ff < CNT_W'(MAX_SPOTS));
   assign frame_end = accept && (req_frame_empty || req_last_spot);

   assign wr_en      = store;
   assign wr_addr    = cnt_ff[IDX_W-1:0];
   assign wr_data    = req_spot;
   assign push       = frame_end;
   assign push_count = cnt_ff + CNT_W'(store);

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (frame_end) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else begin
         if (store) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (frame_done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- sv/lsep_queue.sv -----
`timescale 1ns / 1ps
module lsep_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import lsep_pkg::*;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       fill_ff;
   logic             do_pop, do_push;

   assign pop_valid = (fill_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;
   assign do_push   = push && (fill_ff != 2'd2);

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

// ----- sv/lsep_back.sv -----
`timescale 1ns / 1ps
module lsep_back #(
   parameter int MAX_SPOTS   = lsep_pkg::MAX_SPOTS_DEF,
   parameter int MAX_ERASERS = lsep_pkg::MAX_ERASERS_DEF,
   parameter int MAX_PENS    = lsep_pkg::MAX_PENS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lsep_pkg::cfg_type                     cfg,
   input  logic                                  q_valid,
   input  logic [lsep_pkg::cnt_w(MAX_SPOTS)-1:0] q_count,
   output logic                                  q_pop,
   output logic [lsep_pkg::idx_w(MAX_SPOTS)-1:0] rd_addr,
   input  lsep_pkg::spot_type                    rd_data,
   output logic                                  frame_done,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lsep_pkg::KIND_W-1:0]           rsp_point_kind,
   output logic signed [lsep_pkg::COORD_W-1:0]   rsp_point_x,
   output logic signed [lsep_pkg::COORD_W-1:0]   rsp_point_y,
   output logic                                  rsp_last_point
);
   import lsep_pkg::*;

   localparam int CNT_W  = cnt_w(MAX_SPOTS);
   localparam int IDX_W  = idx_w(MAX_SPOTS);
   localparam int ECNT_W = cnt_w(MAX_ERASERS);
   localparam int EIDX_W = idx_w(MAX_ERASERS);
   localparam int PCNT_W = cnt_w(MAX_PENS);
   localparam int MASS_W = MASS_IN_W + $clog2(MAX_SPOTS);
   localparam int ML_W   = 14;
   localparam int MB_W   = MASS_IN_W;
   localparam int ACC_W  = COORD_W + MASS_W + 2;
   localparam int Q_W    = COORD_W + 1;
   localparam int DC_W   = $clog2(Q_W);
   localparam int SQ_W   = 2 * COORD_W + 1;
   localparam int LIM_W  = 2 * RADIUS_W;
   localparam int PROD_W = COORD_W + MB_W + 1;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_SD_ADDR = 5'd1;
   localparam logic [4:0] ST_SD_CHK  = 5'd2;
   localparam logic [4:0] ST_MG_ADDR = 5'd3;
   localparam logic [4:0] ST_MG_SQ   = 5'd4;
   localparam logic [4:0] ST_MG_CMP  = 5'd5;
   localparam logic [4:0] ST_MUL0    = 5'd6;
   localparam logic [4:0] ST_MUL1    = 5'd7;
   localparam logic [4:0] ST_MUL2    = 5'd8;
   localparam logic [4:0] ST_DIV0    = 5'd9;
   localparam logic [4:0] ST_DIV     = 5'd10;
   localparam logic [4:0] ST_DIVW    = 5'd11;
   localparam logic [4:0] ST_HIST    = 5'd12;
   localparam logic [4:0] ST_HM      = 5'd13;
   localparam logic [4:0] ST_HM_CMP  = 5'd14;
   localparam logic [4:0] ST_HC      = 5'd15;
   localparam logic [4:0] ST_HC_ADDR = 5'd16;
   localparam logic [4:0] ST_HC_SQ   = 5'd17;
   localparam logic [4:0] ST_HC_CMP  = 5'd18;
   localparam logic [4:0] ST_EM_E    = 5'd19;
   localparam logic [4:0] ST_EM_P    = 5'd20;
   localparam logic [4:0] ST_EM_PD   = 5'd21;
   localparam logic [4:0] ST_EM_PW   = 5'd22;
   localparam logic [4:0] ST_EM_END  = 5'd23;

   logic [4:0]                state_ff, state_in;
   logic [CNT_W-1:0]          n_ff, n_in, s_ff, s_in, k_ff, k_in;
   logic [ECNT_W-1:0]         i_ff, i_in, hj_ff, hj_in, ners_ff, ners_in, hc_ff, hc_in;
   logic [PCNT_W-1:0]         pens_ff, pens_in;
   logic [MAX_SPOTS-1:0]      merged_ff, merged_in;
   logic [MAX_ERASERS-1:0]    hm_ff, hm_in;
   logic                      got_ff, got_in, ax_ff, ax_in, neg_ff, neg_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [MASS_W-1:0]         mass_ff, mass_in, tot_ff, tot_in;
   logic [MASS_IN_W-1:0]      m2_ff, m2_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-2:0]          rem_ff, rem_in, dsh_ff, dsh_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic [DC_W-1:0]           dcnt_ff, dcnt_in;
   logic [LIM_W-1:0]          lim_ff, lim_in;
   logic [FACTOR_W-1:0]       factor_ff, factor_in;
   logic signed [COORD_W-1:0] erx_ff [MAX_ERASERS];
   logic signed [COORD_W-1:0] ery_ff [MAX_ERASERS];
   logic signed [COORD_W-1:0] hix_ff [MAX_ERASERS];
   logic signed [COORD_W-1:0] hiy_ff [MAX_ERASERS];
   logic signed [COORD_W-1:0] erx_in [MAX_ERASERS];
   logic signed [COORD_W-1:0] ery_in [MAX_ERASERS];
   logic signed [COORD_W-1:0] hix_in [MAX_ERASERS];
   logic signed [COORD_W-1:0] hiy_in [MAX_ERASERS];
   logic [SQ_W-1:0]           sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic                      pend_ff, pend_in;
   logic [KIND_W-1:0]         pkind_ff, pkind_in;
   logic signed [COORD_W-1:0] pxo_ff, pxo_in, pyo_ff, pyo_in;
   logic                      ov_ff, ov_in, olast_ff, olast_in;
   logic [KIND_W-1:0]         okind_ff, okind_in;
   logic signed [COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;

   // datapath helpers
   logic signed [COORD_W-1:0] opa_x, opa_y, opb_x, opb_y;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [SQ_W:0]      sqx_full, sqy_full;
   logic [SQ_W:0]             sq_sum;
   logic                      near, cand, can_push, can_prod;
   logic [AREA_W+FACTOR_W-1:0] thr;
   logic signed [COORD_W-1:0] mul_a;
   logic [MB_W-1:0]           mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [ACC_W-1:0]          acc_mag;
   logic [MASS_W-1:0]         tot_sum;
   logic                      ge;
   logic [Q_W-1:0]            q_signed;
   logic [ECNT_W-1:0]         ners_nx;
   logic                      prod_req;
   logic [KIND_W-1:0]         prod_kind;
   logic signed [COORD_W-1:0] prod_x, prod_y;
   logic [IDX_W-1:0]          kx, sxi;
   logic [EIDX_W-1:0]         ix, hjx, nx;

   assign kx  = k_ff[IDX_W-1:0];
   assign sxi = s_ff[IDX_W-1:0];
   assign ix  = i_ff[EIDX_W-1:0];
   assign hjx = hj_ff[EIDX_W-1:0];
   assign nx  = ners_ff[EIDX_W-1:0];

   assign dx       = {opa_x[COORD_W-1], opa_x} - {opb_x[COORD_W-1], opb_x};
   assign dy       = {opa_y[COORD_W-1], opa_y} - {opb_y[COORD_W-1], opb_y};
   assign sqx_full = dx * dx;
   assign sqy_full = dy * dy;
   assign sq_sum   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign near     = sq_sum < (SQ_W + 1)'(lim_ff);

   assign thr  = rd_data.area * factor_ff;
   assign cand = thr < (AREA_W + FACTOR_W)'(rd_data.mass);

   assign prod     = mul_a * $signed({1'b0, mul_b});
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign tot_sum  = mass_ff + MASS_W'(m2_ff);
   assign ge       = rem_ff >= dsh_ff;
   assign q_signed = neg_ff ? (Q_W'(0) - q_ff) : q_ff;

   assign can_push = !ov_ff || !rsp_stall;
   assign can_prod = !pend_ff || can_push;

   always_comb begin
      state_in = state_ff;  n_in = n_ff;  s_in = s_ff;  k_in = k_ff;
      i_in = i_ff;  hj_in = hj_ff;  ners_in = ners_ff;  hc_in = hc_ff;  pens_in = pens_ff;
      merged_in = merged_ff;  hm_in = hm_ff;  got_in = got_ff;  ax_in = ax_ff;
      neg_in = neg_ff;  px_in = px_ff;  py_in = py_ff;  sx_in = sx_ff;  sy_in = sy_ff;
      mass_in = mass_ff;  tot_in = tot_ff;  m2_in = m2_ff;  acc_in = acc_ff;
      rem_in = rem_ff;  dsh_in = dsh_ff;  q_in = q_ff;  dcnt_in = dcnt_ff;
      lim_in = lim_ff;  factor_in = factor_ff;
      erx_in = erx_ff;  ery_in = ery_ff;  hix_in = hix_ff;  hiy_in = hiy_ff;
      pend_in = pend_ff;  pkind_in = pkind_ff;  pxo_in = pxo_ff;  pyo_in = pyo_ff;
      ov_in = ov_ff;  olast_in = olast_ff;  okind_in = okind_ff;  ox_in = ox_ff;  oy_in = oy_ff;

      q_pop      = 1'b0;
      frame_done = 1'b0;
      rd_addr    = kx;
      opa_x      = px_ff;
      opa_y      = py_ff;
      opb_x      = rd_data.x;
      opb_y      = rd_data.y;
      mul_a      = ax_ff ? py_ff : px_ff;
      mul_b      = MB_W'(mass_ff[ML_W-1:0]);
      ners_nx    = ners_ff;
      prod_req   = 1'b0;
      prod_kind  = KIND_PEN;
      prod_x     = sx_ff;
      prod_y     = sy_ff;

      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               n_in      = q_count;
               s_in      = '0;
               merged_in = '0;
               hm_in     = '0;
               ners_in   = '0;
               lim_in    = cfg.merge_radius * cfg.merge_radius;
               factor_in = cfg.eraser_factor;
               if (cfg.eraser_enable) begin
                  state_in = ST_SD_ADDR;
               end else begin
                  hc_in    = '0;
                  state_in = ST_HIST;
               end
            end
         end
         ST_SD_ADDR: begin
            rd_addr = sxi;
            if (s_ff == n_ff) begin
               state_in = ST_HIST;
            end else begin
               state_in = ST_SD_CHK;
            end
         end
         ST_SD_CHK: begin
            if (cand && !merged_ff[sxi]) begin
               px_in          = rd_data.x;
               py_in          = rd_data.y;
               mass_in        = MASS_W'(rd_data.mass);
               merged_in[sxi] = 1'b1;
               k_in           = '0;
               state_in       = ST_MG_ADDR;
            end else begin
               s_in     = s_ff + 1'b1;
               state_in = ST_SD_ADDR;
            end
         end
         ST_MG_ADDR: begin
            if (k_ff == n_ff) begin
               if (ners_ff < ECNT_W'(MAX_ERASERS)) begin
                  erx_in[nx] = px_ff;
                  ery_in[nx] = py_ff;
                  ners_in    = ners_ff + 1'b1;
               end
               s_in     = s_ff + 1'b1;
               state_in = ST_SD_ADDR;
            end else if (merged_ff[kx]) begin
               k_in = k_ff + 1'b1;
            end else begin
               state_in = ST_MG_SQ;
            end
         end
         ST_MG_SQ: begin
            sx_in    = rd_data.x;
            sy_in    = rd_data.y;
            m2_in    = rd_data.mass;
            state_in = ST_MG_CMP;
         end
         ST_MG_CMP: begin
            if (near) begin
               merged_in[kx] = 1'b1;
               tot_in        = tot_sum;
               if (tot_sum != '0) begin
                  ax_in    = 1'b0;
                  state_in = ST_MUL0;
               end else begin
                  mass_in  = tot_sum;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_MG_ADDR;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_MG_ADDR;
            end
         end
         // numerator = p * mass + s * m2, mass taken in two slices
         ST_MUL0: begin
            acc_in   = ACC_W'(prod);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            mul_b    = MB_W'(mass_ff[MASS_W-1:ML_W]);
            acc_in   = acc_ff + (ACC_W'(prod) <<< ML_W);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a    = ax_ff ? sy_ff : sx_ff;
            mul_b    = m2_ff;
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = ST_DIV0;
         end
         ST_DIV0: begin
            neg_in   = acc_ff[ACC_W-1];
            rem_in   = acc_mag[ACC_W-2:0];
            dsh_in   = {1'b0, tot_ff, {COORD_W{1'b0}}};
            q_in     = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         // restoring divide, one quotient bit per cycle
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            q_in    = {q_ff[Q_W-2:0], ge};
            dsh_in  = dsh_ff >> 1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DC_W'(Q_W - 1)) begin
               state_in = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (!ax_ff) begin
               px_in    = q_signed[COORD_W-1:0];
               ax_in    = 1'b1;
               state_in = ST_MUL0;
            end else begin
               py_in    = q_signed[COORD_W-1:0];
               mass_in  = tot_ff;
               k_in     = k_ff + 1'b1;
               state_in = ST_MG_ADDR;
            end
         end
         ST_HIST: begin
            i_in  = '0;
            hj_in = '0;
            if ((ners_ff < ECNT_W'(MAX_ERASERS)) && (n_ff != '0)) begin
               state_in = ST_HM;
            end else begin
               state_in = ST_EM_E;
            end
         end
         ST_HM: begin
            opa_x = erx_ff[ix];
            opa_y = ery_ff[ix];
            opb_x = hix_ff[hjx];
            opb_y = hiy_ff[hjx];
            if (i_ff == ners_ff) begin
               i_in     = '0;
               state_in = ST_HC;
            end else if (hj_ff == hc_ff) begin
               i_in  = i_ff + 1'b1;
               hj_in = '0;
            end else if (hm_ff[hjx]) begin
               hj_in = hj_ff + 1'b1;
            end else begin
               state_in = ST_HM_CMP;
            end
         end
         ST_HM_CMP: begin
            if (near) begin
               hm_in[hjx] = 1'b1;
            end
            hj_in    = hj_ff + 1'b1;
            state_in = ST_HM;
         end
         ST_HC: begin
            if (i_ff == hc_ff) begin
               i_in     = '0;
               state_in = ST_EM_E;
            end else if (hm_ff[ix]) begin
               i_in = i_ff + 1'b1;
            end else begin
               k_in     = '0;
               got_in   = 1'b0;
               state_in = ST_HC_ADDR;
            end
         end
         ST_HC_ADDR: begin
            if (k_ff == n_ff) begin
               if (got_ff && (ners_ff < ECNT_W'(MAX_ERASERS))) begin
                  erx_in[nx] = hix_ff[ix];
                  ery_in[nx] = hiy_ff[ix];
                  ners_nx    = ners_ff + 1'b1;
               end
               ners_in = ners_nx;
               if (ners_nx >= ECNT_W'(MAX_ERASERS)) begin
                  i_in     = '0;
                  state_in = ST_EM_E;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_HC;
               end
            end else if (merged_ff[kx]) begin
               k_in = k_ff + 1'b1;
            end else begin
               state_in = ST_HC_SQ;
            end
         end
         ST_HC_SQ: begin
            opa_x    = hix_ff[ix];
            opa_y    = hiy_ff[ix];
            sx_in    = rd_data.x;
            sy_in    = rd_data.y;
            state_in = ST_HC_CMP;
         end
         ST_HC_CMP: begin
            if (near) begin
               merged_in[kx] = 1'b1;
               hix_in[ix]    = sx_ff;
               hiy_in[ix]    = sy_ff;
               got_in        = 1'b1;
            end
            k_in     = k_ff + 1'b1;
            state_in = ST_HC_ADDR;
         end
         ST_EM_E: begin
            if (i_ff == ners_ff) begin
               hc_in    = ners_ff;
               k_in     = '0;
               pens_in  = '0;
               state_in = ST_EM_P;
            end else if (can_prod) begin
               prod_req   = 1'b1;
               prod_kind  = KIND_ERASER;
               prod_x     = erx_ff[ix];
               prod_y     = ery_ff[ix];
               hix_in[ix] = erx_ff[ix];
               hiy_in[ix] = ery_ff[ix];
               i_in       = i_ff + 1'b1;
            end
         end
         ST_EM_P: begin
            if ((k_ff == n_ff) || (pens_ff == PCNT_W'(MAX_PENS))) begin
               state_in = ST_EM_END;
            end else if (merged_ff[kx]) begin
               k_in = k_ff + 1'b1;
            end else begin
               state_in = ST_EM_PD;
            end
         end
         ST_EM_PD: begin
            sx_in    = rd_data.x;
            sy_in    = rd_data.y;
            state_in = ST_EM_PW;
         end
         ST_EM_PW: begin
            if (can_prod) begin
               prod_req = 1'b1;
               pens_in  = pens_ff + 1'b1;
               k_in     = k_ff + 1'b1;
               state_in = ST_EM_P;
            end
         end
         ST_EM_END: begin
            if (can_push) begin
               ov_in    = 1'b1;
               olast_in = 1'b1;
               if (pend_ff) begin
                  okind_in = pkind_ff;
                  ox_in    = pxo_ff;
                  oy_in    = pyo_ff;
                  pend_in  = 1'b0;
               end else begin
                  okind_in = KIND_NONE;
                  ox_in    = '0;
                  oy_in    = '0;
               end
               frame_done = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      sqx_in = sqx_full[SQ_W-1:0];
      sqy_in = sqy_full[SQ_W-1:0];

      // one result held back so the frame's final one can be flagged
      if (prod_req) begin
         if (pend_ff) begin
            ov_in    = 1'b1;
            olast_in = 1'b0;
            okind_in = pkind_ff;
            ox_in    = pxo_ff;
            oy_in    = pyo_ff;
         end
         pend_in  = 1'b1;
         pkind_in = prod_kind;
         pxo_in   = prod_x;
         pyo_in   = prod_y;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;  s_ff <= s_in;  k_ff <= k_in;  i_ff <= i_in;  hj_ff <= hj_in;
      ners_ff <= ners_in;  pens_ff <= pens_in;  merged_ff <= merged_in;  hm_ff <= hm_in;
      got_ff <= got_in;  ax_ff <= ax_in;  neg_ff <= neg_in;
      px_ff <= px_in;  py_ff <= py_in;  sx_ff <= sx_in;  sy_ff <= sy_in;
      mass_ff <= mass_in;  tot_ff <= tot_in;  m2_ff <= m2_in;  acc_ff <= acc_in;
      rem_ff <= rem_in;  dsh_ff <= dsh_in;  q_ff <= q_in;  dcnt_ff <= dcnt_in;
      lim_ff <= lim_in;  factor_ff <= factor_in;
      erx_ff <= erx_in;  ery_ff <= ery_in;  hix_ff <= hix_in;  hiy_ff <= hiy_in;
      sqx_ff <= sqx_in;  sqy_ff <= sqy_in;
      pkind_ff <= pkind_in;  pxo_ff <= pxo_in;  pyo_ff <= pyo_in;
      olast_ff <= olast_in;  okind_ff <= okind_in;  ox_ff <= ox_in;  oy_ff <= oy_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         hc_ff    <= '0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hc_ff    <= hc_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_valid      = ov_ff;
   assign rsp_point_kind = okind_ff;
   assign rsp_point_x    = ox_ff;
   assign rsp_point_y    = oy_ff;
   assign rsp_last_point = olast_ff;

endmodule

// ----- sv/light_spot_eraser_pen_split.sv -----
`timescale 1ns / 1ps
// Light spot eraser/pen splitter. Spots of a frame stream in on the req_
// channel, one transfer per cycle while req_stall is low, and are written to an
// on-chip spot store (spots past MAX_SPOTS are dropped). The transfer carrying
// last_spot or frame_empty closes the frame: the front end hands the spot count
// through a two-entry queue to the back end and then holds req_stall high until
// the back end has queued the frame's final result. The back end is a sequencer
// around one shared squared-distance unit, one multiplier and a 17-step divider.
// Per frame it runs a seed scan over the spots, checks each unmerged spot for
// each eraser seed or each unmatched remembered eraser, spends three multiply
// steps and a divide for each axis on every spot absorbed into an eraser,
// matches each eraser against each history entry, and emits pens. Results leave
// through a registered rsp_ stage; one result is held back so the final one can
// carry last_point. A frame that yields nothing gives one kind-2 result at 0,0.
module light_spot_eraser_pen_split #(
   parameter int MAX_SPOTS   = lsep_pkg::MAX_SPOTS_DEF,
   parameter int MAX_ERASERS = lsep_pkg::MAX_ERASERS_DEF,
   parameter int MAX_PENS    = lsep_pkg::MAX_PENS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // spot input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [lsep_pkg::COORD_W-1:0] req_spot_x,
   input  logic signed [lsep_pkg::COORD_W-1:0] req_spot_y,
   input  logic [lsep_pkg::MASS_IN_W-1:0]      req_spot_mass,
   input  logic [lsep_pkg::AREA_W-1:0]         req_standard_area,
   input  logic                                req_last_spot,
   input  logic                                req_frame_empty,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lsep_pkg::KIND_W-1:0]         rsp_point_kind,
   output logic signed [lsep_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [lsep_pkg::COORD_W-1:0] rsp_point_y,
   output logic                                rsp_last_point,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsep_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsep_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lsep_pkg::*;

   localparam int CNT_W = cnt_w(MAX_SPOTS);
   localparam int IDX_W = idx_w(MAX_SPOTS);

   // configuration registers, to be written only while idle (the block itself does not enforce it)
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic                enable_ff, enable_in;
   cfg_type             cfg;

   assign csr_ready = 1'b1;

   always_comb begin
      radius_in = radius_ff;
      factor_in = factor_ff;
      enable_in = enable_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MERGE_RADIUS:  radius_in = csr_data[RADIUS_W-1:0];
            CSR_ERASER_FACTOR: factor_in = csr_data[FACTOR_W-1:0];
            CSR_ERASER_ENABLE: enable_in = csr_data[0];
            default: ;  // unmapped index: write ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         factor_ff <= FACTOR_RST;
         enable_ff <= 1'b1;
      end else begin
         radius_ff <= radius_in;
         factor_ff <= factor_in;
         enable_ff <= enable_in;
      end
   end

   assign cfg.merge_radius  = radius_ff;
   assign cfg.eraser_factor = factor_ff;
   assign cfg.eraser_enable = enable_ff;

   spot_type         req_spot;
   spot_type         wr_data, rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             push, pop, pop_valid, frame_done;
   logic [CNT_W-1:0] push_count, pop_count;

   assign req_spot.x    = req_spot_x;
   assign req_spot.y    = req_spot_y;
   assign req_spot.mass = req_spot_mass;
   assign req_spot.area = req_standard_area;

   // front end: collects the frame into the store
   lsep_front #(.MAX_SPOTS(MAX_SPOTS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_spot        (req_spot),
      .req_last_spot   (req_last_spot),
      .req_frame_empty (req_frame_empty),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .push            (push),
      .push_count      (push_count),
      .frame_done      (frame_done)
   );

   // spot store: x, y, mass, area packed in one word
   lsep_ram #(.WIDTH($bits(spot_type)), .DEPTH(MAX_SPOTS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // closed frames waiting for the back end
   lsep_queue #(.WIDTH(CNT_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_count),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_count)
   );

   // back end: eraser merge, history capture, emission
   lsep_back #(
      .MAX_SPOTS   (MAX_SPOTS),
      .MAX_ERASERS (MAX_ERASERS),
      .MAX_PENS    (MAX_PENS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (pop_valid),
      .q_count        (pop_count),
      .q_pop          (pop),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .frame_done     (frame_done),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_kind (rsp_point_kind),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

endmodule

// ----- sv/lsep_checker.sv -----
`timescale 1ns / 1ps
module lsep_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_last_spot,
   input logic                                req_frame_empty,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [lsep_pkg::KIND_W-1:0]         rsp_point_kind,
   input logic signed [lsep_pkg::COORD_W-1:0] rsp_point_x,
   input logic signed [lsep_pkg::COORD_W-1:0] rsp_point_y,
   input logic                                rsp_last_point
);
   import lsep_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_kind)
         && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_last_point))
      else $error("stalled result changed");

   // a frame-closing transfer blocks further input
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_last_spot || req_frame_empty) |=> req_stall)
      else $error("input not stalled after frame end");

   // the empty-frame marker is always the frame's final result and sits at 0,0
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_point_kind == KIND_NONE) |-> rsp_last_point
         && (rsp_point_x == '0) && (rsp_point_y == '0))
      else $error("empty-frame result malformed");

   // no result kind beyond nothing-found
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_point_kind == KIND_ERASER) || (rsp_point_kind == KIND_PEN)
         || (rsp_point_kind == KIND_NONE))
      else $error("bad result kind");

endmodule

bind light_spot_eraser_pen_split lsep_checker u_lsep_checker (.*);
